[hw/rtl/baro_pressure_temp_compensation_top_defines.svh]
// Assertion helpers shared by the compensation block.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_TOP_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bpc_pkg.sv]
`default_nettype none
package bpc_pkg;

  // Stream and port widths
  localparam int RAW_W       = 24;
  localparam int OUT_W       = 32;
  localparam int CFG_W       = 24;
  localparam int REG_IDX_W   = 4;
  localparam int FIN_W       = 64;

  // Coefficient widths
  localparam int COEF_WIDE_W = 20;
  localparam int COEF_W      = 16;
  localparam int TCOEF_W     = 12;

  // Fixed point: Q24 intermediates; raw scale 253952 = 31 << 13
  localparam int QBITS       = 24;
  localparam int SCALE_ODD   = 31;
  localparam int SCALE_ODD_W = 5;
  localparam int FRAC_SH     = 11;

  // Pipeline depths
  localparam int SCALE_LAT   = 3;
  localparam int CELL_LAT    = 4;

  // Parameter defaults
  localparam int RAW_BITS_DEF = 24;
  localparam int OUT_FRAC_DEF = 8;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_C00  = 4'd0,
    REG_C10  = 4'd1,
    REG_C01  = 4'd2,
    REG_C11  = 4'd3,
    REG_C20  = 4'd4,
    REG_C21  = 4'd5,
    REG_C30  = 4'd6,
    REG_TEMP = 4'd7
  } reg_idx_t;

  function automatic int wmax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/bpc_delay.sv]
`default_nettype none
module bpc_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule
`default_nettype wire

[hw/rtl/bpc_mac_cell.sv]
`default_nettype none
// y = floor(a * b / 2^SH) + c, four registered steps:
// partial products, pair sums, full product, shift and add.
module bpc_mac_cell #(
  parameter int A_W = 31,
  parameter int B_W = 16,
  parameter int C_W = 40,
  parameter int Y_W = 48,
  parameter int SH  = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [A_W-1:0] a,
  input  logic signed [B_W-1:0] b,
  input  logic signed [C_W-1:0] c,
  output logic signed [Y_W-1:0] y
);

  localparam int AL_W   = A_W / 2;
  localparam int AH_W   = A_W - AL_W;
  localparam int BL_W   = B_W / 2;
  localparam int BH_W   = B_W - BL_W;
  localparam int PROD_W = A_W + B_W;
  localparam int EXT_W  = (PROD_W > Y_W + SH) ? PROD_W : Y_W + SH;
  localparam int LL_W   = AL_W + BL_W;
  localparam int LH_W   = AL_W + BH_W + 1;
  localparam int HL_W   = AH_W + BL_W + 1;
  localparam int HH_W   = AH_W + BH_W;

  logic        [AL_W-1:0]      al;
  logic signed [AH_W-1:0]      ah;
  logic        [BL_W-1:0]      bl;
  logic signed [BH_W-1:0]      bh;

  logic        [AL_W+BL_W-1:0] ll_q;
  logic signed [AL_W+BH_W:0]   lh_q;
  logic signed [AH_W+BL_W:0]   hl_q;
  logic signed [AH_W+BH_W-1:0] hh_q;
  logic signed [C_W-1:0]       c1_q, c2_q, c3_q;

  logic signed [PROD_W-1:0]    t_ll, t_lh, t_hl, t_hh;
  logic signed [PROD_W-1:0]    lo_q, hi_q, prod_q;
  logic signed [EXT_W-1:0]     prod_ext, prod_sh;
  logic signed [Y_W-1:0]       y_q;

  assign al = a[AL_W-1:0];
  assign ah = $signed(a[A_W-1:AL_W]);
  assign bl = b[BL_W-1:0];
  assign bh = $signed(b[B_W-1:BL_W]);

  assign t_ll = PROD_W'(ll_q);
  assign t_lh = PROD_W'(lh_q);
  assign t_hl = PROD_W'(hl_q);
  assign t_hh = PROD_W'(hh_q);

  assign prod_ext = EXT_W'(prod_q);
  assign prod_sh  = prod_ext >>> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_q   <= LL_W'(al) * LL_W'(bl);
      lh_q   <= LH_W'($signed({1'b0, al})) * LH_W'(bh);
      hl_q   <= HL_W'(ah) * HL_W'($signed({1'b0, bl}));
      hh_q   <= HH_W'(ah) * HH_W'(bh);
      c1_q   <= c;
      lo_q   <= t_ll + (t_lh <<< BL_W);
      hi_q   <= t_hl + (t_hh <<< BL_W);
      c2_q   <= c1_q;
      prod_q <= lo_q + (hi_q <<< AL_W);
      c3_q   <= c2_q;
      y_q    <= Y_W'(prod_sh) + Y_W'(c3_q);
    end
  end

  assign y = y_q;

endmodule
`default_nettype wire

[hw/rtl/bpc_scale.sv]
`default_nettype none
// p = floor(raw * 2^11 / 31), raw taken as RAW_BITS two's complement.
// Bias raw positive, divide by 31 through a reciprocal with one fix step,
// then add the fractional part of the remainder.
module bpc_scale #(
  parameter int RAW_BITS = 24
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bpc_pkg::RAW_W-1:0]   raw,
  output logic signed [RAW_BITS+6:0]  p
);
  import bpc_pkg::*;

  localparam int P_W    = RAW_BITS + 7;
  localparam int RU_W   = RAW_BITS + 1;
  localparam int M_W    = RAW_BITS + 2;
  localparam int DIV_SH = RAW_BITS + 6;
  localparam int PR_W   = RU_W + M_W;
  localparam int Q_W    = PR_W - DIV_SH;
  localparam int REM_W  = SCALE_ODD_W + 1;
  localparam int FRAC_INT = (1 << FRAC_SH) / SCALE_ODD;
  localparam int FRAC_REM = (1 << FRAC_SH) % SCALE_ODD;

  localparam logic [RU_W-1:0] OFS   = RU_W'(SCALE_ODD) << (RAW_BITS - SCALE_ODD_W);
  localparam logic [M_W-1:0]  RECIP = M_W'((64'd1 << DIV_SH) / SCALE_ODD);
  localparam logic [P_W-1:0]  BIAS  = P_W'(1) << (P_W - 1);

  logic [RU_W-1:0]        r_u;
  logic [RU_W-1:0]        ru_q;
  logic [PR_W-1:0]        prod_q;
  logic [Q_W-1:0]         q0;
  logic [Q_W-1:0]         q0_q;
  logic [RU_W-1:0]        rem_full;
  logic [REM_W-1:0]       rem_q;
  logic                   fix;
  logic [Q_W:0]           qa;
  logic [REM_W-1:0]       ra_full;
  logic [SCALE_ODD_W-1:0] ra;
  logic [FRAC_SH-1:0]     frac;
  logic [P_W-1:0]         p_next;
  logic signed [P_W-1:0]  p_q;

  assign r_u = RU_W'($signed(raw[RAW_BITS-1:0])) + OFS;

  assign q0       = prod_q[PR_W-1:DIV_SH];
  assign rem_full = ru_q - RU_W'({q0, SCALE_ODD_W'(0)}) + RU_W'(q0);

  always_comb begin
    fix     = (rem_q >= REM_W'(SCALE_ODD));
    qa      = fix ? (Q_W+1)'(q0_q) + (Q_W+1)'(1) : (Q_W+1)'(q0_q);
    ra_full = fix ? rem_q - REM_W'(SCALE_ODD) : rem_q;
    ra      = ra_full[SCALE_ODD_W-1:0];
    // floor(2^11 * ra / 31): the rest term stays below twice the divisor
    frac    = FRAC_SH'(FRAC_INT * int'(ra))
            + FRAC_SH'(((FRAC_REM * int'(ra)) >= SCALE_ODD) ? 1 : 0);
    p_next  = P_W'({qa, FRAC_SH'(0)}) + P_W'(frac) - BIAS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ru_q   <= r_u;
      prod_q <= PR_W'(r_u) * PR_W'(RECIP);
      q0_q   <= q0;
      rem_q  <= rem_full[REM_W-1:0];
      p_q    <= $signed(p_next);
    end
  end

  assign p = p_q;

endmodule
`default_nettype wire

[hw/rtl/baro_pressure_temp_compensation_top.sv]
`default_nettype none
`include "baro_pressure_temp_compensation_top_defines.svh"
// Barometric pressure and temperature compensation.
// Input stream (s_t*): one raw pressure / raw temperature pair per item.
// Output stream (m_t*): compensated pressure and temperature, 8 fraction
// bits by default, saturated to 32 bits; m_tuser flags a saturation.
// Config channel (cfg_*): write coefficient register cfg_index with
// cfg_data; cfg_ready is always high. Write only while no item is in flight.
// Throughput: one item per cycle while s_tready is high; the raw scaler and
// the rows of 4-stage multiply-add cells, each cell splitting its product
// into four partial products, are fully pipelined.
// Reset clears all coefficients, the stage valids and both output slots.
// When the receiver stalls, the output register holds its result and a skid
// slot takes the next one; only then does s_tready drop and the whole chain
// freeze until the output is taken.
module baro_pressure_temp_compensation_top #(
  parameter int RAW_BITS      = bpc_pkg::RAW_BITS_DEF,
  parameter int OUT_FRAC_BITS = bpc_pkg::OUT_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic [2*bpc_pkg::RAW_W-1:0]       s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] pressure_comp, [63:32] temperature_comp
  output logic [2*bpc_pkg::OUT_W-1:0]       m_tdata,
  // [0] overflow
  output logic [0:0]                        m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpc_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]         cfg_data
);
  import bpc_pkg::*;

  localparam int P_W  = RAW_BITS + 7;
  localparam int I1_W = wmax(P_W + COEF_W, COEF_W + QBITS) + 1;
  localparam int X_W  = I1_W;
  localparam int TP_W = 2 * P_W - QBITS;
  localparam int F1_W = wmax(P_W + COEF_W, COEF_WIDE_W + QBITS) + 1;
  localparam int TC_W = wmax(P_W + TCOEF_W, TCOEF_W + QBITS - 1) + 1;
  localparam int I2_W = wmax(P_W + I1_W - QBITS, COEF_WIDE_W + QBITS) + 1;
  localparam int TX_W = wmax(TP_W + X_W - QBITS, F1_W) + 1;
  localparam int PC_W = wmax(P_W + I2_W - QBITS, TX_W) + 1;
  localparam int LAT  = SCALE_LAT + 3 * CELL_LAT + 1;
  localparam int OUT_SH = QBITS - OUT_FRAC_BITS;

  typedef struct packed {
    logic             ovf;
    logic [OUT_W-1:0] t;
    logic [OUT_W-1:0] p;
  } res_t;

  // Coefficient registers
  logic signed [COEF_WIDE_W-1:0] c00, c10;
  logic signed [COEF_W-1:0]      c01, c11, c20, c21, c30;
  logic        [CFG_W-1:0]       temp_coefs;
  logic signed [TCOEF_W-1:0]     c0, c1;

  logic signed [COEF_W+QBITS-1:0]      c20_q, c11_q;
  logic signed [COEF_WIDE_W+QBITS-1:0] c10_q, c00_q;
  logic signed [TCOEF_W+QBITS-2:0]     c0_half;

  logic              en;
  logic [LAT-1:0]    vld;
  logic              fin_valid;

  logic signed [P_W-1:0]  p0, t0, p4, p8;
  logic signed [I1_W-1:0] inner1;
  logic signed [X_W-1:0]  xc;
  logic signed [TP_W-1:0] tp;
  logic signed [F1_W-1:0] tc1;
  logic signed [TC_W-1:0] tcomp, tcomp8;
  logic signed [I2_W-1:0] inner2;
  logic signed [TX_W-1:0] tx;
  logic signed [PC_W-1:0] pc;

  logic [OUT_W:0] fp, ft;
  res_t           fin_res, out_res, skid_res;
  logic           out_valid, skid_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      c00        <= '0;
      c10        <= '0;
      c01        <= '0;
      c11        <= '0;
      c20        <= '0;
      c21        <= '0;
      c30        <= '0;
      temp_coefs <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_C00:  c00        <= cfg_data[COEF_WIDE_W-1:0];
        REG_C10:  c10        <= cfg_data[COEF_WIDE_W-1:0];
        REG_C01:  c01        <= cfg_data[COEF_W-1:0];
        REG_C11:  c11        <= cfg_data[COEF_W-1:0];
        REG_C20:  c20        <= cfg_data[COEF_W-1:0];
        REG_C21:  c21        <= cfg_data[COEF_W-1:0];
        REG_C30:  c30        <= cfg_data[COEF_W-1:0];
        REG_TEMP: temp_coefs <= cfg_data;
        default: ;
      endcase
    end
  end

  assign c0      = $signed(temp_coefs[2*TCOEF_W-1:TCOEF_W]);
  assign c1      = $signed(temp_coefs[TCOEF_W-1:0]);
  assign c20_q   = {c20, QBITS'(0)};
  assign c11_q   = {c11, QBITS'(0)};
  assign c10_q   = {c10, QBITS'(0)};
  assign c00_q   = {c00, QBITS'(0)};
  assign c0_half = {c0, (QBITS-1)'(0)};

  // Stall only when the skid slot is taken
  assign en       = !skid_full;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  assign fin_valid = vld[LAT-1];

  bpc_scale #(.RAW_BITS(RAW_BITS)) u_scale_p (
    .clk(clk), .en(en), .raw(s_tdata[RAW_W-1:0]), .p(p0)
  );

  bpc_scale #(.RAW_BITS(RAW_BITS)) u_scale_t (
    .clk(clk), .en(en), .raw(s_tdata[2*RAW_W-1:RAW_W]), .p(t0)
  );

  // First row: independent products of the scaled words
  bpc_mac_cell #(
    .A_W(P_W), .B_W(COEF_W), .C_W(COEF_W+QBITS), .Y_W(I1_W), .SH(0)
  ) u_cell_inner1 (
    .clk(clk), .en(en), .a(p0), .b(c30), .c(c20_q), .y(inner1)
  );

  bpc_mac_cell #(
    .A_W(P_W), .B_W(COEF_W), .C_W(COEF_W+QBITS), .Y_W(X_W), .SH(0)
  ) u_cell_cross (
    .clk(clk), .en(en), .a(p0), .b(c21), .c(c11_q), .y(xc)
  );

  bpc_mac_cell #(
    .A_W(P_W), .B_W(P_W), .C_W(1), .Y_W(TP_W), .SH(QBITS)
  ) u_cell_tp (
    .clk(clk), .en(en), .a(t0), .b(p0), .c(1'b0), .y(tp)
  );

  bpc_mac_cell #(
    .A_W(P_W), .B_W(COEF_W), .C_W(COEF_WIDE_W+QBITS), .Y_W(F1_W), .SH(0)
  ) u_cell_toff (
    .clk(clk), .en(en), .a(t0), .b(c01), .c(c00_q), .y(tc1)
  );

  bpc_mac_cell #(
    .A_W(P_W), .B_W(TCOEF_W), .C_W(TCOEF_W+QBITS-1), .Y_W(TC_W), .SH(0)
  ) u_cell_temp (
    .clk(clk), .en(en), .a(t0), .b(c1), .c(c0_half), .y(tcomp)
  );

  bpc_delay #(.W(P_W), .DEPTH(CELL_LAT)) u_dly_p4 (
    .clk(clk), .en(en), .d(p0), .q(p4)
  );

  // Second row
  bpc_mac_cell #(
    .A_W(P_W), .B_W(I1_W), .C_W(COEF_WIDE_W+QBITS), .Y_W(I2_W), .SH(QBITS)
  ) u_cell_inner2 (
    .clk(clk), .en(en), .a(p4), .b(inner1), .c(c10_q), .y(inner2)
  );

  bpc_mac_cell #(
    .A_W(TP_W), .B_W(X_W), .C_W(F1_W), .Y_W(TX_W), .SH(QBITS)
  ) u_cell_tx (
    .clk(clk), .en(en), .a(tp), .b(xc), .c(tc1), .y(tx)
  );

  bpc_delay #(.W(P_W), .DEPTH(CELL_LAT)) u_dly_p8 (
    .clk(clk), .en(en), .d(p4), .q(p8)
  );

  // Third row: close the Horner chain
  bpc_mac_cell #(
    .A_W(P_W), .B_W(I2_W), .C_W(TX_W), .Y_W(PC_W), .SH(QBITS)
  ) u_cell_pc (
    .clk(clk), .en(en), .a(p8), .b(inner2), .c(tx), .y(pc)
  );

  bpc_delay #(.W(TC_W), .DEPTH(2*CELL_LAT)) u_dly_tc (
    .clk(clk), .en(en), .d(tcomp), .q(tcomp8)
  );

  // Floor to the output fraction, saturate to 32 bits; MSB flags saturation
  function automatic logic [OUT_W:0] finish(input logic signed [FIN_W-1:0] x);
    logic signed [FIN_W-1:0]  y;
    logic [FIN_W-OUT_W:0]     hi;
    logic [OUT_W:0]           r;
    y  = x >>> OUT_SH;
    hi = y[FIN_W-1:OUT_W-1];
    if ((&hi) || !(|hi)) begin
      r = {1'b0, y[OUT_W-1:0]};
    end else if (y[FIN_W-1]) begin
      r = {1'b1, 1'b1, (OUT_W-1)'(0)};
    end else begin
      r = {1'b1, 1'b0, {(OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

  always_comb begin
    fp = finish(FIN_W'(pc));
    ft = finish(FIN_W'(tcomp8));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_res.p   <= fp[OUT_W-1:0];
      fin_res.t   <= ft[OUT_W-1:0];
      fin_res.ovf <= fp[OUT_W] | ft[OUT_W];
    end
  end

  // Output register with skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (!out_valid || m_tready) begin
        if (skid_full) begin
          out_valid <= 1'b1;
          out_res   <= skid_res;
          skid_full <= 1'b0;
        end else begin
          out_valid <= fin_valid;
          out_res   <= fin_res;
        end
      end else if (fin_valid && !skid_full) begin
        skid_res  <= fin_res;
        skid_full <= 1'b1;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.t, out_res.p};
  assign m_tuser  = out_res.ovf;

  `BPC_ASSERT_IMP(a_skid_needs_out, clk, rst, skid_full, out_valid,
                  "skid slot holds an item while the output register is empty")
  `BPC_ASSERT_NEXT(a_skid_catch, clk, rst,
                   out_valid && !m_tready && fin_valid && !skid_full, skid_full,
                   "finished item not caught by the skid slot")
  `BPC_ASSERT_NEXT(a_out_load, clk, rst,
                   fin_valid && !skid_full && (!out_valid || m_tready), out_valid,
                   "finished item not moved to the output register")
  `BPC_ASSERT_NEXT(a_stall_hold, clk, rst, skid_full, $stable(vld),
                   "pipeline advanced while stalled")

endmodule
`default_nettype wire
